>>> rtl/core/flpa_pkg.sv
// Package for the free list pool allocator: codes, states, defaults.
// No dependencies.
package flpa_pkg;
    localparam int unsigned DefDepth     = 256;
    localparam int unsigned DefAddrWidth = 32;
    localparam int unsigned CfgIdxW      = 2;
    localparam int unsigned CfgDataW     = 32;
    localparam int unsigned DivW         = 32;
    localparam int unsigned DivCntW      = 6;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_INIT   = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NULL      = 3'd2,
        ST_INVALID   = 3'd3,
        ST_DOUBLE    = 3'd4,
        ST_UNDERFLOW = 3'd5
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_BASE = 2'd0,
        CFG_ELEM = 2'd1,
        CFG_CAP  = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ARD, S_AMUL, S_ADONE, S_FCHK, S_FDIV, S_FWAIT,
        S_FMARK, S_FMARK2, S_INIT, S_OUT
    } t_state;

    // divider handshake
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;
endpackage

>>> rtl/core/flpa_if.sv
// Valid/ready channel interface, generic payload type.
// Depends on nothing.
interface flpa_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/free_list_pool_allocator.sv
// Channel      Dir  Payload
// req_if       in   action, object_address
// rsp_if       out  status, block_address, block_index, used_count, peak_usage, totals
// cfg          in   i_cfg_we / i_cfg_idx / i_cfg_data, no read-back
// Allocate reads the stack and multiplies; free waits on the 32-step divider.
// Reinitialize sweeps the stack one entry a cycle. Reset loads the stack the same
// way in a single pass, during which no request is taken.
// One request at a time; the result register holds until taken.
module free_list_pool_allocator
    import flpa_pkg::*;
#(
    parameter int unsigned DEPTH = DefDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    flpa_if.sink                req_if,
    flpa_if.source              rsp_if
);
    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = IW + 1;

    logic [31:0] r_base;
    logic [15:0] r_elem;
    logic [8:0]  r_cap;

    logic [IW-1:0] r_stack [DEPTH];
    logic          r_mark  [DEPTH];
    logic [CW-1:0] r_head, r_free;
    logic [8:0]    r_peak;
    logic [31:0]   r_atot, r_ftot;

    t_state        r_st, n_st;
    logic [1:0]    r_act;
    logic [31:0]   r_addr;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_rd;
    logic          r_mrd;
    logic [47:0]   r_prod;
    logic [CW-1:0] r_sweep;
    logic          r_init_rst;
    logic [CW-1:0] r_effcap;

    t_status     r_o_status;
    logic [31:0] r_o_baddr;
    logic [7:0]  r_o_bidx;
    logic [8:0]  r_o_used;
    logic [8:0]  r_o_peak;
    logic [31:0] r_o_atot, r_o_ftot;
    logic        r_o_valid;

    t_div_ctl        w_dctl;
    t_div_sts        w_dsts;
    logic [DivW-1:0] w_quo;
    logic [15:0]     w_rem;
    logic [31:0]     w_off;
    logic [CW-1:0]   w_cap, w_used;
    logic            w_take;

    assign w_cap = (r_cap > 9'(DEPTH > 511 ? 511 : DEPTH)) ? CW'(DEPTH) : CW'(r_cap);
    assign w_used = (r_free > w_cap) ? '0 : w_cap - r_free;
    assign w_off  = r_addr - r_base;
    assign w_take = req_if.valid && req_if.ready;
    assign req_if.ready = (r_st == S_IDLE) && !r_o_valid && !r_init_rst;

    flpa_div u_div (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_dctl),
        .i_num (w_off), .i_den (r_elem), .o_sts (w_dsts),
        .o_quo (w_quo), .o_rem (w_rem)
    );

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:   if (w_take) n_st = S_DECODE;
            S_DECODE: begin
                unique case (t_action'(r_act))
                    ACT_ALLOC:  n_st = (r_free == '0 || r_head >= CW'(DEPTH)) ? S_OUT : S_ARD;
                    ACT_FREE:   n_st = S_FCHK;
                    ACT_INIT:   n_st = S_INIT;
                    default:    n_st = S_OUT;
                endcase
            end
            S_ARD:    n_st = S_AMUL;
            S_AMUL:   n_st = S_ADONE;
            S_ADONE:  n_st = S_OUT;
            S_FCHK:   n_st = (r_addr == '0 || r_addr < r_base) ? S_OUT : S_FDIV;
            S_FDIV:   n_st = S_FWAIT;
            S_FWAIT:  if (w_dsts.done) n_st = S_FMARK;
            S_FMARK:  n_st = S_FMARK2;
            S_FMARK2: n_st = S_OUT;
            S_INIT:   if (r_sweep == CW'(DEPTH - 1)) n_st = S_OUT;
            S_OUT:    n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
        if (r_init_rst) n_st = S_IDLE;
    end

    always_comb begin
        w_dctl.start = (r_st == S_FDIV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= S_IDLE;
            r_base     <= 32'd65536;
            r_elem     <= 16'd16;
            r_cap      <= 9'd256;
            r_head     <= '0;
            r_free     <= CW'(DEPTH);
            r_peak     <= '0;
            r_atot     <= '0;
            r_ftot     <= '0;
            r_o_valid  <= 1'b0;
            r_sweep    <= '0;
            r_init_rst <= 1'b1;
            r_effcap   <= CW'(DEPTH);
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BASE: r_base <= i_cfg_data;
                    CFG_ELEM: r_elem <= i_cfg_data[15:0];
                    CFG_CAP:  r_cap  <= i_cfg_data[8:0];
                    default:  ;
                endcase
            end
            if (rsp_if.valid && rsp_if.ready) r_o_valid <= 1'b0;
            if (r_init_rst) begin
                r_sweep <= r_sweep + 1'b1;
                if (r_sweep == CW'(DEPTH - 1)) begin
                    r_init_rst <= 1'b0;
                    r_sweep    <= '0;
                end
            end
            unique case (r_st)
                S_DECODE: begin
                    r_o_status <= ST_OK;
                    r_o_baddr  <= '0;
                    r_o_bidx   <= '0;
                    r_effcap   <= w_cap;
                    r_sweep    <= '0;
                    if (t_action'(r_act) == ACT_ALLOC &&
                        (r_free == '0 || r_head >= CW'(DEPTH)))
                        r_o_status <= ST_EMPTY;
                end
                S_AMUL: begin
                    r_prod <= 48'(r_rd) * 48'(r_elem);
                    r_head <= r_head + 1'b1;
                    r_free <= r_free - 1'b1;
                    r_atot <= r_atot + 1'b1;
                end
                S_ADONE: begin
                    r_o_baddr <= r_base + r_prod[31:0];
                    r_o_bidx  <= 8'(r_rd);
                    if (9'(w_used) > r_peak) r_peak <= 9'(w_used);
                end
                S_FCHK: begin
                    if (r_addr == '0) r_o_status <= ST_NULL;
                    else if (r_addr < r_base) r_o_status <= ST_INVALID;
                end
                S_FMARK: begin
                    r_prod <= 48'(r_effcap) * 48'(r_elem);
                end
                S_FMARK2: begin
                    if ({16'd0, w_off} >= r_prod || w_rem != '0) begin
                        r_o_status <= ST_INVALID;
                    end else begin
                        r_o_bidx <= 8'(w_quo);
                        if (!r_mrd) r_o_status <= ST_DOUBLE;
                        else if (r_head == '0) r_o_status <= ST_UNDERFLOW;
                        else begin
                            r_head <= r_head - 1'b1;
                            r_free <= r_free + 1'b1;
                            r_ftot <= r_ftot + 1'b1;
                        end
                    end
                end
                S_INIT: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == CW'(DEPTH - 1)) begin
                        r_head <= '0;
                        r_free <= r_effcap;
                        r_peak <= '0;
                        r_atot <= '0;
                        r_ftot <= '0;
                    end
                end
                S_OUT: begin
                    r_o_valid <= 1'b1;
                    r_o_used  <= 9'(w_used);
                    r_o_peak  <= r_peak;
                    r_o_atot  <= r_atot;
                    r_o_ftot  <= r_ftot;
                end
                default: ;
            endcase
        end
    end

    // memories and request capture
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_act  <= req_if.data.action;
            r_addr <= req_if.data.object_address;
        end
        r_rd  <= r_stack[r_head[IW-1:0]];
        r_mrd <= r_mark[w_quo[IW-1:0]];
        r_idx <= w_quo[IW-1:0];
        if (r_init_rst) begin
            r_stack[r_sweep[IW-1:0]] <= IW'(CW'(DEPTH - 1) - r_sweep);
            r_mark[r_sweep[IW-1:0]]  <= 1'b0;
        end else if (r_st == S_INIT) begin
            r_stack[r_sweep[IW-1:0]] <= (r_sweep < r_effcap) ?
                IW'(r_effcap - 1'b1 - r_sweep) : '0;
            r_mark[r_sweep[IW-1:0]] <= 1'b0;
        end else if (r_st == S_AMUL) begin
            r_mark[r_rd] <= 1'b1;
        end else if (r_st == S_FMARK2 && !({16'd0, w_off} >= r_prod || w_rem != '0)
                     && r_mrd) begin
            r_mark[r_idx] <= 1'b0;
            if (r_head != '0) r_stack[IW'(r_head - 1'b1)] <= r_idx;
        end
    end

    assign rsp_if.valid                   = r_o_valid;
    assign rsp_if.data.status             = r_o_status;
    assign rsp_if.data.block_address      = r_o_baddr;
    assign rsp_if.data.block_index        = r_o_bidx;
    assign rsp_if.data.used_count         = r_o_used;
    assign rsp_if.data.peak_usage         = r_o_peak;
    assign rsp_if.data.total_allocations  = r_o_atot;
    assign rsp_if.data.total_frees        = r_o_ftot;

    logic w_unused;
    assign w_unused = ^{w_dsts.busy, w_quo[DivW-1:IW], r_prod[47:32]};
endmodule

>>> rtl/core/flpa_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on flpa_pkg.
module flpa_div
    import flpa_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_div_ctl        i_ctl,
    input  logic [DivW-1:0] i_num,
    input  logic [15:0]     i_den,
    output t_div_sts        o_sts,
    output logic [DivW-1:0] o_quo,
    output logic [15:0]     o_rem
);
    logic [DivW-1:0]    r_quo, n_quo;
    logic [16:0]        r_rem, n_rem;
    logic [15:0]        r_den;
    logic [DivCntW-1:0] r_cnt, n_cnt;
    logic               r_busy, n_busy, r_done, n_done;
    logic [16:0]        w_sh;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem[15:0], r_quo[DivW-1]};
        if (i_ctl.start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_quo = {r_quo[DivW-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[DivW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DivCntW'(DivW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_ctl.start) r_den <= i_den;
    end

    assign o_sts = '{busy: r_busy, done: r_done};
    assign o_quo = r_quo;
    assign o_rem = r_rem[15:0];
endmodule

>>> rtl/core/flpa_chk.sv
// Port-level checker for free_list_pool_allocator, bound to the top level.
// Depends on flpa_pkg.
module flpa_chk
    import flpa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic [2:0] i_status,
    input logic [31:0] i_baddr
);
    a_no_req_while_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready) else $error("request taken with result pending");
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready) else $error("ready after accept");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status <= ST_UNDERFLOW)) else $error("bad status");
    a_addr0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status != ST_OK) |-> (i_baddr == '0)) else $error("addr on error");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> $stable(i_status)) else $error("result moved");
endmodule

bind free_list_pool_allocator flpa_chk u_flpa_chk (
    .i_clk (i_clk), .i_rst_n (i_rst_n),
    .i_req_valid (req_if.valid), .i_req_ready (req_if.ready),
    .i_rsp_valid (rsp_if.valid), .i_rsp_ready (rsp_if.ready),
    .i_status (rsp_if.data.status), .i_baddr (rsp_if.data.block_address)
);
